// ===== sv/ghist_pkg.sv =====
// Shared types and codes for the gray-level histogram unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package ghist_pkg;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int FIELD_W     = 8;
    localparam int OUT_COUNT_W = 32;

    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic clr_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic out_blocked;
    } dp_status_t;

endpackage

// ===== sv/ghist_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module ghist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ghist_ctrl.sv =====
// Controller state machine of the histogram unit: clearing pass, accept, update.
// Depends on ghist_pkg.
module ghist_ctrl
    import ghist_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.update   = 1'b0;
        cmd.clr_step = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!(status.is_read && status.out_blocked))
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/ghist_dp.sv =====
// Datapath of the histogram unit: bin RAM, item registers, clear counter, result register.
// Depends on ghist_pkg and ghist_ram.
module ghist_dp
    import ghist_pkg::*;
#(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int IDX_W  = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 1;
    localparam int CMP_W  = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

    logic                   in_op;
    logic [FIELD_W-1:0]     in_pixel;
    logic [FIELD_W-1:0]     in_sel;
    logic [FIELD_W-1:0]     in_idx;
    logic [IDX_W-1:0]       in_idx_ext;
    logic                   in_range;

    logic                   op_reg;
    logic [FIELD_W-1:0]     idx_reg;
    logic                   in_range_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [ADDR_W-1:0]      clr_cnt_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0]  ram_wdata;
    logic [COUNT_BITS-1:0]  ram_rdata;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [CMP_W-1:0]       cnt_ext;
    logic [OUT_COUNT_W-1:0] cnt_sat;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [FIELD_W-1:0]     out_index_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg;
    logic                   out_load;

    assign in_op      = s_tdata[0];
    assign in_pixel   = s_tdata[FIELD_W:1];
    assign in_sel     = s_tdata[2*FIELD_W:FIELD_W+1];
    assign in_idx     = (in_op == OP_READ) ? in_sel : in_pixel;
    assign in_idx_ext = IDX_W'(in_idx);
    assign in_range   = in_idx_ext < IDX_W'(NUM_BINS);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= in_op;
            idx_reg      <= in_idx;
            in_range_reg <= in_range;
            addr_reg     <= in_idx_ext[ADDR_W-1:0];
        end
    end

    assign clr_cnt_next = cmd.clr_step ? clr_cnt_reg + ADDR_W'(1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign cnt_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (cmd.update && in_range_reg)
        begin
            ram_we    = 1'b1;
            ram_wdata = (op_reg == OP_READ) ? '0 : cnt_inc;
        end
    end

    ghist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (in_idx_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign cnt_ext = CMP_W'(ram_rdata);
    assign cnt_sat = (cnt_ext > CMP_W'({OUT_COUNT_W{1'b1}})) ? '1 : cnt_ext[OUT_COUNT_W-1:0];

    assign out_load       = cmd.update && (op_reg == OP_READ);
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= idx_reg;
            out_count_reg <= in_range_reg ? cnt_sat : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_index_reg};

    assign status.clr_last    = clr_cnt_reg == ADDR_W'(NUM_BINS - 1);
    assign status.is_read     = op_reg == OP_READ;
    assign status.out_blocked = out_valid_reg && !m_tready;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && !m_tready))
        else $error("Result register loaded while a result transfer is pending.");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !cmd.accept && !cmd.update)
        else $error("Item handled during the clearing pass.");

    a_out_of_range_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !in_range_reg) |-> !ram_we)
        else $error("Out-of-range bin written.");

    a_update_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !$past(cmd.update))
        else $error("Two updates in a row without an accepted item.");

endmodule

// ===== sv/gray_level_histogram_unit.sv =====
// Top level of the gray-level histogram unit.
// Depends on ghist_pkg, ghist_ctrl and ghist_dp.
//
// Input stream (s_*): one transfer is one item. op = 0 counts pixel_value into
// its bin and gives no result; op = 1 reads the bin named by bin_select,
// returns its count and clears it. Pixels beyond NUM_BINS are ignored; a read
// beyond NUM_BINS returns zero. Counts saturate at their largest value.
// Output stream (m_*): one transfer per read item, in item order.
//
// Each item passes through ST_IDLE, where the accept cycle issues the bin RAM read,
// and ST_UPDATE, which writes the updated count back, so no new item is accepted
// until the previous one has been written back. A result is registered and appears
// on m_tvalid in the cycle after the update cycle.
//
// After reset the bin RAM is cleared one entry per cycle; s_tready stays low
// until the last entry is cleared. When the receiver stalls, the result register holds
// its result; count items still go on, and a further read item waits in its
// update cycle until the pending result transfer completes.
module gray_level_histogram_unit
    import ghist_pkg::*;
#(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // op, pixel_value, bin_select, zero fill
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // bin_index, bin_count
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ghist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ghist_dp #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for gray_level_histogram_unit: drives count and read
// items with random idling on both streams and checks every returned bin count.
// Depends on ghist_pkg and the gray_level_histogram_unit RTL.
module testbench;
    import ghist_pkg::*;

    localparam int NUM_BINS    = 256;
    localparam int COUNT_BITS  = 32;
    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [FIELD_W-1:0]     bin_idx;
        logic [OUT_COUNT_W-1:0] bin_cnt;
    } bin_readout_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [COUNT_BITS-1:0]  shadow_bins [NUM_BINS];
    bin_readout_t           pending_readouts [$];
    int                     mismatches = 0;
    int                     items_sent = 0;
    int                     quiet_cycles = 0;
    bit                     no_idle = 1'b0;

    gray_level_histogram_unit #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 22);
        end
    end

    // Mirrors the bin store: counts saturate, reads return and clear.
    task automatic update_histogram(input op_t op, input logic [7:0] pix,
                                    input logic [7:0] sel);
        bin_readout_t     r;
        logic [63:0]      held;
        if (op == OP_COUNT)
        begin
            if (32'(pix) < NUM_BINS && shadow_bins[pix] != {COUNT_BITS{1'b1}})
            begin
                shadow_bins[pix] = shadow_bins[pix] + COUNT_BITS'(1);
            end
        end
        else
        begin
            r.bin_idx = sel;
            r.bin_cnt = '0;
            if (32'(sel) < NUM_BINS)
            begin
                held = 64'(shadow_bins[sel]);
                r.bin_cnt = (held > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : held[31:0];
                shadow_bins[sel] = '0;
            end
            pending_readouts.push_back(r);
        end
    endtask

    task automatic send_item(input op_t op, input logic [7:0] pix, input logic [7:0] sel);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 22)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({sel, pix, logic'(op)});
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        update_histogram(op, pix, sel);
        items_sent++;
    endtask

    task automatic count_pixel(input logic [7:0] pix);
        send_item(OP_COUNT, pix, 8'($urandom));
    endtask

    task automatic read_bin(input logic [7:0] sel);
        send_item(OP_READ, 8'($urandom), sel);
    endtask

    task automatic wait_for_readouts();
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_empty_after_reset();
        read_bin(8'h00);
        read_bin(8'hFF);
        read_bin(8'h5A);
    endtask

    task automatic test_directed_cases();
        send_item(OP_COUNT, 8'h00, 8'hFF);
        send_item(OP_COUNT, 8'hFF, 8'h00);
        count_pixel(8'hFF);
        count_pixel(8'hFF);
        read_bin(8'hFF);
        read_bin(8'hFF);
        send_item(OP_READ, 8'hFF, 8'h00);
        count_pixel(8'hAA);
        read_bin(8'hAA);
        count_pixel(8'h55);
        count_pixel(8'h55);
        send_item(OP_READ, 8'h55, 8'h55);
        count_pixel(8'h80);
        count_pixel(8'h01);
        count_pixel(8'h80);
        read_bin(8'h01);
        read_bin(8'h80);
        read_bin(8'h7F);
    endtask

    task automatic test_pause_until_drained();
        count_pixel(8'h10);
        count_pixel(8'h10);
        read_bin(8'h10);
        wait_for_readouts();
        read_bin(8'h10);
        count_pixel(8'h20);
        read_bin(8'h20);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int i = 0; i < 120; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                read_bin(8'($urandom_range(0, 15)));
            end
            else
            begin
                count_pixel(8'($urandom_range(0, 15)));
            end
        end
        no_idle = 1'b0;
    endtask

    // Short count images, each with a partial readout; maybe a sweep; noise.
    task automatic test_random_images();
        int       kind;
        int       npix;
        int       nread;
        logic [7:0] base;
        bit       swept;
        swept = 1'b0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                base  = 8'($urandom);
                npix  = $urandom_range(20, 80);
                nread = $urandom_range(6, 20);
                for (int i = 0; i < npix; i++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        count_pixel(base + 8'($urandom_range(0, 15)));
                    end
                    else
                    begin
                        count_pixel(8'($urandom));
                    end
                end
                for (int i = 0; i < nread; i++)
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        read_bin(base + 8'($urandom_range(0, 15)));
                    end
                    else
                    begin
                        read_bin(8'($urandom));
                    end
                end
            end
            else if (kind == 7 && !swept)
            begin
                swept = 1'b1;
                for (int b = 0; b < NUM_BINS; b++)
                begin
                    read_bin(8'(b));
                end
            end
            else
            begin
                for (int i = 0; i < 30; i++)
                begin
                    send_item(op_t'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        bin_readout_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readouts.size() == 0)
            begin
                $display("%0t: unexpected result index %0d count %0d", $time,
                         m_tdata[7:0], m_tdata[39:8]);
                mismatches++;
            end
            else
            begin
                exp_r = pending_readouts.pop_front();
                if (m_tdata[7:0] !== exp_r.bin_idx)
                begin
                    $display("%0t: bin_index expected %0d actual %0d", $time,
                             exp_r.bin_idx, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[39:8] !== exp_r.bin_cnt)
                begin
                    $display("%0t: bin_count of bin %0d expected %0d actual %0d", $time,
                             exp_r.bin_idx, exp_r.bin_cnt, m_tdata[39:8]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        for (int b = 0; b < NUM_BINS; b++)
        begin
            shadow_bins[b] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_after_reset();
        test_directed_cases();
        test_pause_until_drained();
        test_back_to_back();
        test_random_images();
        wait_for_readouts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_readouts.size() == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
